FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/srge_pkg.sv
// shared constants of the scalar rls gain estimator
package srge_pkg;

  // default number format, signed Q16.32 in 48 bits
  localparam int DATA_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 32;

  // bits of the second operand consumed per multiplier pass
  localparam int MUL_CHUNK = 16;

  // covariance loaded at reset, about 1e-3 in Q16.32
  localparam logic [63:0] INIT_COV_RESET = 64'd4294967;

endpackage

FILE: rtl/core/scalar_rls_gain_estimator.sv
// scalar recursive least squares estimator with a shared multiplier and serial divider
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------------
//  s_axis    | in  | prior_estimate, predicted, measured, clear
//  m_axis    | out | new_estimate (tdata), saturated (tuser)
//  cfg       | in  | initial_covariance, written when cfg_we is high
//
//  QBITS, the quotient width of the restoring divider (one quotient bit per cycle),
//  is DATA_WIDTH, or FRAC_BITS+2 when one saturates; six products go through the
//  one chunked multiplier. s_axis_tready is high only while the sequencer idles.
//  a finished result waits in the output register, the next beat is taken meanwhile.
//  synchronous reset clears gain, loads covariance and the register default.
module scalar_rls_gain_estimator #(
  parameter int DATA_WIDTH = srge_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = srge_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = ((3 * DATA_WIDTH + 8) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-2:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // prior_estimate, predicted, measured, clear, zero fill
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_estimate, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser
);

  localparam int W           = DATA_WIDTH;
  localparam int F           = FRAC_BITS;
  localparam int CH          = srge_pkg::MUL_CHUNK;
  localparam int NCH         = (W + CH - 1) / CH;
  localparam int PADW        = NCH * CH;
  localparam bit ONE_CLIPPED = (F > W - 2);
  localparam int QBITS       = ONE_CLIPPED ? F + 2 : W;
  localparam int NW          = W + F;
  localparam int MAGW        = (2 * W > QBITS) ? 2 * W : QBITS;
  localparam int CNT_MAX     = (QBITS > NCH) ? QBITS : NCH;
  localparam int CNTW        = $clog2(CNT_MAX + 1);

  localparam logic signed [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_V = ONE_CLIPPED ? MAXV : (W'(1) << F);
  localparam logic [W-2:0] COV_RST      = srge_pkg::INIT_COV_RESET[W-2:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MFIN,
    S_POST,
    S_DIV,
    S_DFIN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ST_XL,
    ST_GE,
    ST_CX,
    ST_XT,
    ST_DV,
    ST_KX,
    ST_FC
  } step_t;

  // magnitude of a signed value, the most negative one fits unsigned
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? -a : a;
  endfunction

  // sign extend by one bit
  function automatic logic signed [W:0] sext(input logic signed [W-1:0] a);
    return {a[W-1], a};
  endfunction

  // clip a one-bit-wider sum, flag in the top bit
  function automatic logic [W:0] clip_sum(input logic signed [W:0] s);
    logic [W:0] r;
    if (s[W] != s[W-1]) begin
      r = {1'b1, (s[W] ? MINV : MAXV)};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  // sign and wide magnitude to a clipped value, flag in the top bit
  function automatic logic [W:0] clip_mag(input logic neg, input logic [MAGW-1:0] m);
    logic [MAGW-1:0] lim;
    logic [W-1:0]    v;
    logic            s;
    lim = neg ? (MAGW'(1) << (W - 1)) : ((MAGW'(1) << (W - 1)) - MAGW'(1));
    if (m > lim) begin
      s = 1'b1;
      v = lim[W-1:0];
    end else begin
      s = 1'b0;
      v = m[W-1:0];
    end
    if (neg) begin
      v = -v;
    end
    return {s, v};
  endfunction

  state_t state;
  step_t  step;

  // configuration and estimator state
  logic [W-2:0]        init_cov;
  logic signed [W-1:0] gain;
  logic signed [W-1:0] cov;

  // latched item and intermediate results
  logic signed [W-1:0] l_r, x_r, y_r;
  logic                clr_r;
  logic signed [W-1:0] est_r, t_r, d_r, k_r, mres;
  logic                sat_r;

  // multiplier
  logic [W-1:0]        ma_mag;
  logic [PADW-1:0]     mb_sh;
  logic                mneg;
  logic [2*W-1:0]      acc;
  logic [W+CH-1:0]     mul_prod;
  logic [W:0]          mul_clip;

  // divider
  logic [QBITS-1:0]    nreg;
  logic [QBITS-1:0]    quo;
  logic [W-1:0]        rem;
  logic [W:0]          rem_sh;
  logic                div_ge;
  logic [W:0]          div_diff;
  logic [W-1:0]        div_rem;
  logic [W:0]          div_clip;
  logic [NW-1:0]       n_full;

  logic [CNTW-1:0]     cnt;

  // post-processing adder
  logic signed [W:0]   post_sum;
  logic [W:0]          post_clip;
  logic signed [W-1:0] post_val;
  logic signed [W-1:0] d_val;

  logic [W-1:0]        out_est;
  logic                out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = OUT_W'(out_est);

  // finished result moves into a free or draining output register
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // one chunk of the second operand per cycle, most significant first
  assign mul_prod = ma_mag * mb_sh[PADW-1 -: CH];
  assign mul_clip = clip_mag(mneg, MAGW'(acc >> F));

  // restoring division step
  assign rem_sh   = {rem, nreg[QBITS-1]};
  assign div_diff = rem_sh - {1'b0, d_r};
  assign div_ge   = (rem_sh >= {1'b0, d_r});
  assign div_rem  = div_ge ? div_diff[W-1:0] : rem_sh[W-1:0];
  assign div_clip = clip_mag(t_r[W-1], MAGW'(quo));
  assign n_full   = NW'(mag(t_r)) << F;

  // saturating add selected by the current step
  always_comb begin
    unique case (step)
      ST_XL:   post_sum = sext(y_r) - sext(mres);
      ST_GE:   post_sum = sext(l_r) + sext(mres);
      ST_XT:   post_sum = sext(ONE_V) + sext(mres);
      ST_KX:   post_sum = sext(ONE_V) - sext(mres);
      default: post_sum = sext(mres);
    endcase
    post_clip = clip_sum(post_sum);
    post_val  = post_clip[W-1:0];
    d_val     = (post_val < ONE_V) ? ONE_V : post_val;
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= ST_XL;
      init_cov      <= COV_RST;
      gain          <= '0;
      cov           <= {1'b0, COV_RST};
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_cov <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            l_r    <= s_axis_tdata[W-1:0];
            x_r    <= s_axis_tdata[2*W-1:W];
            y_r    <= s_axis_tdata[3*W-1:2*W];
            clr_r  <= s_axis_tdata[3*W];
            sat_r  <= 1'b0;
            // x * l
            ma_mag <= mag(s_axis_tdata[2*W-1:W]);
            mb_sh  <= PADW'(mag(s_axis_tdata[W-1:0]));
            mneg   <= s_axis_tdata[2*W-1] ^ s_axis_tdata[W-1];
            acc    <= '0;
            cnt    <= CNTW'(NCH);
            step   <= ST_XL;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          acc   <= (acc << CH) + (2 * W)'(mul_prod);
          mb_sh <= mb_sh << CH;
          cnt   <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_MFIN;
          end
        end
        S_MFIN: begin
          mres  <= mul_clip[W-1:0];
          sat_r <= sat_r | mul_clip[W];
          state <= S_POST;
        end
        S_POST: begin
          sat_r <= sat_r | post_clip[W];
          unique case (step)
            ST_XL: begin
              // gain * error
              ma_mag <= mag(gain);
              mb_sh  <= PADW'(mag(post_val));
              mneg   <= gain[W-1] ^ post_val[W-1];
              acc    <= '0;
              cnt    <= CNTW'(NCH);
              step   <= ST_GE;
              state  <= S_MUL;
            end
            ST_GE: begin
              est_r  <= post_val;
              // covariance * x
              ma_mag <= mag(cov);
              mb_sh  <= PADW'(mag(x_r));
              mneg   <= cov[W-1] ^ x_r[W-1];
              acc    <= '0;
              cnt    <= CNTW'(NCH);
              step   <= ST_CX;
              state  <= S_MUL;
            end
            ST_CX: begin
              t_r    <= mres;
              // x * t
              ma_mag <= mag(x_r);
              mb_sh  <= PADW'(mag(mres));
              mneg   <= x_r[W-1] ^ mres[W-1];
              acc    <= '0;
              cnt    <= CNTW'(NCH);
              step   <= ST_XT;
              state  <= S_MUL;
            end
            ST_XT: begin
              // divisor floored at one, start |t| << frac / d
              d_r   <= d_val;
              rem   <= W'(n_full >> QBITS);
              nreg  <= n_full[QBITS-1:0];
              quo   <= '0;
              cnt   <= CNTW'(QBITS);
              state <= S_DIV;
            end
            ST_DV: begin
              // k * x
              ma_mag <= mag(k_r);
              mb_sh  <= PADW'(mag(x_r));
              mneg   <= k_r[W-1] ^ x_r[W-1];
              acc    <= '0;
              cnt    <= CNTW'(NCH);
              step   <= ST_KX;
              state  <= S_MUL;
            end
            ST_KX: begin
              // (one - k*x) * covariance
              ma_mag <= mag(post_val);
              mb_sh  <= PADW'(mag(cov));
              mneg   <= post_val[W-1] ^ cov[W-1];
              acc    <= '0;
              cnt    <= CNTW'(NCH);
              step   <= ST_FC;
              state  <= S_MUL;
            end
            ST_FC: begin
              gain  <= clr_r ? '0 : k_r;
              cov   <= clr_r ? {1'b0, init_cov} : mres;
              state <= S_DONE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DIV: begin
          rem  <= div_rem;
          nreg <= nreg << 1;
          quo  <= {quo[QBITS-2:0], div_ge};
          cnt  <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          k_r   <= div_clip[W-1:0];
          sat_r <= sat_r | div_clip[W];
          step  <= ST_DV;
          state <= S_POST;
        end
        S_DONE: begin
          // hand the result to the output register once it is free
          if (out_load) begin
            out_est      <= est_r;
            m_axis_tuser <= sat_r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/srge_checker.sv
// port-level checks of the scalar rls gain estimator, bound to the top level
`include "assert_macros.svh"

module srge_checker #(
  parameter int OUT_W = 48
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  // an accepted beat keeps the block busy for the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a new result appears only as the sequencer returns to idle
  `ASSERT_IMPLIES(a_result_at_idle, clk, rst, $rose(m_axis_tvalid), s_axis_tready)

  // no result right after reset
  `ASSERT_IMPLIES(a_empty_after_reset, clk, rst, $past(rst), !m_axis_tvalid && s_axis_tready)

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind scalar_rls_gain_estimator srge_checker #(.OUT_W(OUT_W)) u_srge_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

FILE: tb/scalar_rls_gain_estimator_tb.sv
// self-checking testbench of the scalar rls gain estimator
module scalar_rls_gain_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW   = srge_pkg::DATA_WIDTH_DEF;
  localparam int FB   = srge_pkg::FRAC_BITS_DEF;
  localparam int IN_W = ((3 * DW + 8) / 8) * 8;

  localparam longint MAX_V = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint MIN_V = -MAX_V - 1;
  localparam longint ONE_V = longint'(1) <<< FB;

  localparam logic [DW-1:0] MAX_F  = MAX_V[DW-1:0];
  localparam logic [DW-1:0] MIN_F  = MIN_V[DW-1:0];
  localparam logic [DW-1:0] ONE_F  = ONE_V[DW-1:0];
  localparam logic [DW-1:0] BIG_X  = ONE_F << 8;
  localparam logic [DW-2:0] COV_DEFAULT = srge_pkg::INIT_COV_RESET[DW-2:0];

  // idle pause before a register write and at the end, above the per-item latency
  localparam int DRAIN_CYCLES   = 120;
  localparam int HOLD_CYCLES    = 900;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [DW-1:0] estimate;
    logic          clipped;
  } rls_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [DW-2:0]     cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // prior_estimate, predicted, measured, clear, zero fill
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // new_estimate
  logic [DW-1:0]     m_axis_tdata;
  // saturated
  logic              m_axis_tuser;

  // estimator state as the block should hold it
  longint            track_gain = 0;
  longint            track_cov = longint'(COV_DEFAULT);
  logic [DW-2:0]     init_cov_reg = COV_DEFAULT;
  logic              step_clipped;

  rls_result_t       expected_updates[$];
  rls_result_t       taken_update;
  rls_result_t       head_update;
  int                error_count = 0;
  int                quiet_cycles = 0;

  int                send_idle_pct = 20;
  int                recv_idle_pct = 20;
  int                recv_stall = 0;
  logic              hold_request = 1'b0;
  logic              hold_ack = 1'b0;

  always #6 clk = ~clk;

  scalar_rls_gain_estimator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // fixed point helpers, every clip marks the step
  function automatic logic [127:0] mag_of(longint a);
    logic [63:0] u;
    u = (a < 0) ? -a : a;
    return {64'd0, u};
  endfunction

  function automatic longint clip_mag(logic neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? mag_of(MIN_V) : mag_of(MAX_V);
    if (m > lim) begin
      step_clipped = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > MAX_V) begin
      step_clipped = 1'b1;
      return MAX_V;
    end
    if (s < MIN_V) begin
      step_clipped = 1'b1;
      return MIN_V;
    end
    return s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip_mag((a < 0) != (b < 0), (mag_of(a) * mag_of(b)) >> FB);
  endfunction

  // divisor is always positive here
  function automatic longint fx_div(longint n, longint d);
    return clip_mag(n < 0, (mag_of(n) << FB) / mag_of(d));
  endfunction

  function automatic longint sext(logic [DW-1:0] v);
    return {{(64 - DW){v[DW-1]}}, v};
  endfunction

  // one estimator step: correct with the old gain, then new gain and covariance
  function automatic rls_result_t predict_update(longint l, longint x, longint y, logic clr);
    longint      xl, err, est, t, d, k, kx, f, p;
    rls_result_t r;
    step_clipped = 1'b0;
    xl = fx_mul(x, l);
    if (xl == MIN_V) err = fx_add(fx_add(y, MAX_V), 1);
    else err = fx_add(y, -xl);
    est = fx_add(l, fx_mul(track_gain, err));
    t = fx_mul(track_cov, x);
    d = fx_add(ONE_V, fx_mul(x, t));
    if (d < ONE_V) d = ONE_V;
    k = fx_div(t, d);
    kx = fx_mul(k, x);
    if (kx == MIN_V) f = fx_add(fx_add(ONE_V, MAX_V), 1);
    else f = fx_add(ONE_V, -kx);
    p = fx_mul(f, track_cov);
    track_gain = clr ? 0 : k;
    track_cov = clr ? longint'({1'b0, init_cov_reg}) : p;
    r.estimate = est[DW-1:0];
    r.clipped = step_clipped;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DW-1:0] any_field();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: return MAX_F;
      1: return MIN_F;
      2: return '0;
      default: return r[DW-1:0];
    endcase
  endfunction

  // random value of magnitude below 2^bits, either sign
  function automatic longint near_zero(int bits);
    logic [63:0] r;
    longint      v;
    r = {$urandom(), $urandom()};
    v = longint'(r & ((64'd1 << bits) - 1));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // expectation for every input beat taken
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      taken_update = predict_update(sext(s_axis_tdata[DW-1:0]),
                                    sext(s_axis_tdata[2*DW-1:DW]),
                                    sext(s_axis_tdata[3*DW-1:2*DW]),
                                    s_axis_tdata[3*DW]);
      expected_updates = {expected_updates, taken_update};
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_updates.size() == 0) begin
        $display("%0t: result beat with none expected, estimate %h saturated %b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        head_update = expected_updates.pop_front();
        if (m_axis_tdata !== head_update.estimate) begin
          $display("%0t: new_estimate expected %h got %h",
                   $time, head_update.estimate, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== head_update.clipped) begin
          $display("%0t: saturated expected %b got %b",
                   $time, head_update.clipped, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // result side ready, with random stalls and the long hold-off on request
  always begin
    @(negedge clk);
    if (hold_request != hold_ack) begin
      hold_ack = hold_request;
      recv_stall = HOLD_CYCLES;
    end
    if (recv_stall > 0) begin
      m_axis_tready = 1'b0;
      recv_stall--;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      m_axis_tready = 1'b0;
      recv_stall = pick_gap() - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // offer one beat, return at the falling edge after it is taken
  task automatic send_item(logic [DW-1:0] l, logic [DW-1:0] x, logic [DW-1:0] y, logic clr);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {{(IN_W - 3 * DW - 1){1'b0}}, clr, y, x, l};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // plausible tracking data most of the time, arbitrary fields otherwise
  task automatic send_mixed_item(int noise_pct);
    longint l, x, y;
    if ($urandom_range(0, 99) < noise_pct) begin
      send_item(any_field(), any_field(), any_field(), $urandom_range(0, 9) == 0);
    end else begin
      l = ONE_V + near_zero(30);
      x = near_zero(35);
      y = x + (x >>> 4) + near_zero(26);
      send_item(l[DW-1:0], x[DW-1:0], y[DW-1:0], $urandom_range(0, 29) == 0);
    end
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle_idle();
    s_axis_tvalid = 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_init_cov(logic [DW-2:0] v);
    settle_idle();
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    init_cov_reg = v;
  endtask

  // field extremes and the most negative product in the correction
  task automatic test_field_extremes();
    send_item('0, '0, '0, 1'b0);
    send_item(ONE_F, ONE_F, ONE_F, 1'b0);
    send_item(ONE_F, ONE_F, ONE_F << 1, 1'b0);
    send_item(MAX_F, MAX_F, MAX_F, 1'b0);
    send_item(MIN_F, MIN_F, MIN_F, 1'b0);
    send_item(MAX_F, MIN_F, '0, 1'b0);
    send_item(ONE_F, MIN_F, 48'd5, 1'b0);
    send_item(ONE_F, MIN_F, -ONE_F, 1'b0);
    send_item('1, 48'd1, '1, 1'b0);
    send_item(ONE_F, '0, ONE_F, 1'b1);
    send_item(ONE_F, ONE_F, MIN_F, 1'b0);
  endtask

  // huge covariance drives it negative, then the divisor floor takes over
  task automatic test_negative_covariance();
    load_init_cov('1);
    send_item(ONE_F, ONE_F, ONE_F, 1'b1);
    send_item(ONE_F, BIG_X, ONE_F, 1'b0);
    send_item(ONE_F, ONE_F, ONE_F, 1'b0);
    send_item(MIN_F, ONE_F, MAX_F, 1'b0);
    load_init_cov('0);
    send_item(ONE_F, ONE_F, ONE_F, 1'b1);
    send_item(ONE_F, ONE_F + (ONE_F << 1), ONE_F, 1'b0);
  endtask

  // random runs under a range of initial covariance settings
  task automatic test_register_sweep();
    logic [DW-2:0] settings[8];
    logic [63:0]   r;
    settings[0] = '0;
    settings[1] = (DW - 1)'(1);
    settings[2] = COV_DEFAULT;
    settings[3] = ONE_F[DW-2:0];
    settings[4] = ONE_F[DW-2:0] << 12;
    settings[5] = '1;
    r = {$urandom(), $urandom()};
    settings[6] = r[DW-2:0];
    r = {$urandom(), $urandom()};
    settings[7] = r[DW-2:0] >> $urandom_range(0, 20);
    foreach (settings[i]) begin
      load_init_cov(settings[i]);
      send_item(ONE_F, ONE_F, ONE_F, 1'b1);
      repeat (84) send_mixed_item(25);
    end
  endtask

  // back to back on both sides
  task automatic test_no_idle_stretch();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_mixed_item(25);
    send_idle_pct = 20;
    recv_idle_pct = 20;
  endtask

  // result side holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = ~hold_request;
    repeat (12) send_mixed_item(25);
    send_idle_pct = 20;
    recv_idle_pct = 20;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_field_extremes();
    test_negative_covariance();
    test_register_sweep();
    test_no_idle_stretch();
    test_output_backpressure();
    settle_idle();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
